>>> rtl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg: shared types, constants and BCD helpers for the LTC frame builder
// Holds the time-of-day digit struct, item and config types, register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

  localparam logic [15:0] SYNC_WORD   = 16'hBFFC;
  localparam logic [5:0]  FPS_RESET   = 6'd30;
  localparam logic [5:0]  FPS_BIT27   = 6'd30;
  localparam int          POL_BIT_LOW  = 27;
  localparam int          POL_BIT_HIGH = 59;
  localparam int          CFG_AW      = 3;
  localparam int          CFG_DW      = 32;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;

  // Register select, taken from paddr[2]
  typedef enum logic {
    REG_FPS  = 1'b0,
    REG_USER = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [2:0] frame_tens;
    logic [3:0] frame_units;
  } time_t;

  typedef struct packed {
    logic       action;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
    logic [5:0] load_frame;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  fps;
    logic [31:0] user_bits;
  } cfg_t;

  // Binary 0..63 to BCD {tens[2:0], units[3:0]}
  function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] r;
    if (v >= 6'd60) begin
      t = 3'd6; r = v - 6'd60;
    end else if (v >= 6'd50) begin
      t = 3'd5; r = v - 6'd50;
    end else if (v >= 6'd40) begin
      t = 3'd4; r = v - 6'd40;
    end else if (v >= 6'd30) begin
      t = 3'd3; r = v - 6'd30;
    end else if (v >= 6'd20) begin
      t = 3'd2; r = v - 6'd20;
    end else if (v >= 6'd10) begin
      t = 3'd1; r = v - 6'd10;
    end else begin
      t = 3'd0; r = v;
    end
    return {t, r[3:0]};
  endfunction

  function automatic logic [5:0] mod60(input logic [5:0] v);
    return (v >= 6'd60) ? v - 6'd60 : v;
  endfunction

  function automatic logic [4:0] mod24(input logic [4:0] v);
    return (v >= 5'd24) ? v - 5'd24 : v;
  endfunction

  // Step a valid BCD pair by one
  function automatic logic [6:0] bcd_inc(input logic [2:0] t, input logic [3:0] u);
    return (u == 4'd9) ? {t + 3'd1, 4'd0} : {t, u + 4'd1};
  endfunction

endpackage

`default_nettype wire

>>> rtl/ltc_if.sv
// ----------------------------------------------------------------------------
// ltc_if: valid/ready channels for load/tick words and LTC frame words
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [4:0] load_hours;
  logic [5:0] load_minutes;
  logic [5:0] load_seconds;
  logic [5:0] load_frame;

  modport source (output valid, action, load_hours, load_minutes, load_seconds,
                  load_frame, input ready);
  modport sink   (input valid, action, load_hours, load_minutes, load_seconds,
                  load_frame, output ready);
endinterface

interface ltc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_data;
  logic [15:0] sync_word;
  logic        day_wrap;

  modport source (output valid, frame_data, sync_word, day_wrap, input ready);
  modport sink   (input valid, frame_data, sync_word, day_wrap, output ready);
endinterface

`default_nettype wire

>>> rtl/ltc_cfg.sv
// ----------------------------------------------------------------------------
// ltc_cfg: APB register file (frames per second, user bits)
// Writes complete in the access phase; pready is tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_cfg
  import ltc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  logic [5:0]  fps_r;
  logic [31:0] user_r;
  logic        wr_en;
  reg_sel_t    sel;

  assign sel        = reg_sel_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r  <= FPS_RESET;
      user_r <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_FPS:  fps_r  <= cfg_pwdata[5:0];
        REG_USER: user_r <= cfg_pwdata;
        default:  ;
      endcase
    end
  end

  // Unaligned reads return zero
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'd0) begin
      unique case (sel)
        REG_FPS:  cfg_prdata = {{(CFG_DW-6){1'b0}}, fps_r};
        REG_USER: cfg_prdata = user_r;
        default:  cfg_prdata = '0;
      endcase
    end
  end

  assign cfg.fps       = fps_r;
  assign cfg.user_bits = user_r;

endmodule

`default_nettype wire

>>> rtl/ltc_time.sv
// ----------------------------------------------------------------------------
// ltc_time: BCD time-of-day register with preset and frame advance
// Updates once per consumed word; exposes the advanced time for packing.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_time
  import ltc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic go,
  input  wire in_item_t item,
  input  wire logic [5:0] fps,
  output time_t     adv_time,
  output logic      adv_wrap
);

  time_t      time_r;
  time_t      time_nxt;
  time_t      load_time;
  logic [6:0] f_bin;
  logic       f_carry;
  logic       s_carry;
  logic       m_carry;
  logic       h_carry;
  logic [6:0] f_inc;
  logic [6:0] s_inc;
  logic [6:0] m_inc;

  assign f_bin   = 7'(time_r.frame_tens) * 7'd10 + 7'(time_r.frame_units) + 7'd1;
  assign f_carry = !(f_bin < {1'b0, fps});
  assign s_carry = (time_r.sec_tens == 3'd5) && (time_r.sec_units == 4'd9);
  assign m_carry = (time_r.min_tens == 3'd5) && (time_r.min_units == 4'd9);
  assign h_carry = (time_r.hour_tens == 2'd2) && (time_r.hour_units == 4'd3);
  assign f_inc   = bcd_inc(time_r.frame_tens, time_r.frame_units);
  assign s_inc   = bcd_inc(time_r.sec_tens, time_r.sec_units);
  assign m_inc   = bcd_inc(time_r.min_tens, time_r.min_units);

  // Ripple the carry frame -> seconds -> minutes -> hours
  always_comb begin
    adv_time = time_r;
    adv_wrap = 1'b0;
    if (!f_carry) begin
      {adv_time.frame_tens, adv_time.frame_units} = f_inc;
    end else begin
      {adv_time.frame_tens, adv_time.frame_units} = '0;
      if (!s_carry) begin
        {adv_time.sec_tens, adv_time.sec_units} = s_inc;
      end else begin
        {adv_time.sec_tens, adv_time.sec_units} = '0;
        if (!m_carry) begin
          {adv_time.min_tens, adv_time.min_units} = m_inc;
        end else begin
          {adv_time.min_tens, adv_time.min_units} = '0;
          if (h_carry) begin
            {adv_time.hour_tens, adv_time.hour_units} = '0;
            adv_wrap = 1'b1;
          end else if (time_r.hour_units == 4'd9) begin
            adv_time.hour_tens  = time_r.hour_tens + 2'd1;
            adv_time.hour_units = 4'd0;
          end else begin
            adv_time.hour_units = time_r.hour_units + 4'd1;
          end
        end
      end
    end
  end

  always_comb begin
    logic [6:0] hb;
    hb = bin_to_bcd({1'b0, mod24(item.load_hours)});
    load_time.hour_tens  = hb[5:4];
    load_time.hour_units = hb[3:0];
    {load_time.min_tens, load_time.min_units}     = bin_to_bcd(mod60(item.load_minutes));
    {load_time.sec_tens, load_time.sec_units}     = bin_to_bcd(mod60(item.load_seconds));
    {load_time.frame_tens, load_time.frame_units} = bin_to_bcd(item.load_frame);
  end

  assign time_nxt = (item.action == ACT_LOAD) ? load_time : adv_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (go) begin
      time_r <= time_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ltc_pack.sv
// ----------------------------------------------------------------------------
// ltc_pack: assemble LTC bits 0..63 and apply the polarity bit
// Digit nibbles low, user nibbles high, one byte per digit.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_pack
  import ltc_pkg::*;
(
  input  wire time_t         tm,
  input  wire cfg_t          cfg,
  output logic        [63:0] frame_data
);

  logic [7:0][3:0] digits;
  logic [63:0]     raw;
  logic            pol;

  assign digits[0] = tm.frame_units;
  assign digits[1] = {1'b0, tm.frame_tens};
  assign digits[2] = tm.sec_units;
  assign digits[3] = {1'b0, tm.sec_tens};
  assign digits[4] = tm.min_units;
  assign digits[5] = {1'b0, tm.min_tens};
  assign digits[6] = tm.hour_units;
  assign digits[7] = {2'b00, tm.hour_tens};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      raw[8*i +: 8] = {cfg.user_bits[4*i +: 4], digits[i]};
    end
  end

  // Set the polarity bit when the raw parity is even
  assign pol = ~(^raw);

  always_comb begin
    frame_data = raw;
    if (pol) begin
      if (cfg.fps == FPS_BIT27) begin
        frame_data[POL_BIT_LOW] = 1'b1;
      end else begin
        frame_data[POL_BIT_HIGH] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ltc_timecode_frame_builder_top.sv
// ----------------------------------------------------------------------------
// ltc_timecode_frame_builder_top: BCD timecode counter and LTC frame builder
// Load words preset the time; tick words advance it and emit one frame word.
// ----------------------------------------------------------------------------
// Throughput is one word per clock cycle while the output side does not stall:
// each input word lands in an input register, and the time advance, carry
// ripple, byte packing and parity are one short combinational pass from there
// into the result register. A tick word goes from the input register into
// the result register; a load word updates the time and produces no result.
// The input register keeps accepting while a result waits in the output
// register; when the output side stalls and a tick sits in the input
// register, the stall reaches in_ch.ready in the same cycle. Registers:
// frames_per_second at byte 0 (reset 30, also selects polarity bit 27 at
// 30 fps, else bit 59) and user_bits at byte 4 (nibble i lands in the high
// nibble of byte i). Change them only while the block is idle.
`default_nettype none

module ltc_timecode_frame_builder_top
  import ltc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  ltc_in_if.sink                 in_ch,
  ltc_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t        cfg;
  in_item_t    item_r;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s1_tick;
  logic        s1_go;
  logic        out_free;
  logic        in_ready;
  logic        in_fire;
  time_t       adv_time;
  logic        adv_wrap;
  logic [63:0] frame_data_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] frame_data_r;
  logic        day_wrap_r;

  ltc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Input stage: hold one word; release a load at once, a tick when its result has a place
  assign s1_tick  = s1_valid_r && (item_r.action == ACT_TICK);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && ((item_r.action == ACT_LOAD) || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.action       <= in_ch.action;
      item_r.load_hours   <= in_ch.load_hours;
      item_r.load_minutes <= in_ch.load_minutes;
      item_r.load_seconds <= in_ch.load_seconds;
      item_r.load_frame   <= in_ch.load_frame;
    end
  end

  ltc_time u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_go),
    .item     (item_r),
    .fps      (cfg.fps),
    .adv_time (adv_time),
    .adv_wrap (adv_wrap)
  );

  ltc_pack u_pack (
    .tm         (adv_time),
    .cfg        (cfg),
    .frame_data (frame_data_nxt)
  );

  // Result register: load on a released tick, drop when taken
  assign out_valid_nxt = (s1_go && s1_tick) ? 1'b1 :
                         (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_tick) begin
      frame_data_r <= frame_data_nxt;
      day_wrap_r   <= adv_wrap;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_data = frame_data_r;
  assign out_ch.sync_word  = SYNC_WORD;
  assign out_ch.day_wrap   = day_wrap_r;

`ifndef SYNTHESIS
  // A released tick always shows up as a result next cycle
  a_tick_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_tick) |=> out_valid_r)
    else $error("released tick word did not reach the result register");

  // Polarity bit makes every emitted frame odd over bits 0..63
  a_odd_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (^frame_data_r))
    else $error("frame word has even parity");

  // A day wrap leaves every time digit at zero
  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && day_wrap_r) |->
      (frame_data_r[3:0] == 4'd0 && frame_data_r[11:8] == 4'd0 &&
       frame_data_r[19:16] == 4'd0 && frame_data_r[26:24] == 3'd0 &&
       frame_data_r[35:32] == 4'd0 && frame_data_r[43:40] == 4'd0 &&
       frame_data_r[51:48] == 4'd0 && frame_data_r[58:56] == 3'd0))
    else $error("day wrap with nonzero time digits");

  // A load word never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_tick && !out_valid_r) |=> !out_valid_r)
    else $error("load word produced a result");
`endif

endmodule

`default_nettype wire
